>>> rtl/core/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
// Depends on nothing; used by rmq_front, rmq_root_cell and the top level.
`default_nettype none
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IN_W      = 16;
	localparam int W_W       = 15;
	localparam int XYZ_W     = 16;
	localparam int LANES     = 4;

	// signed sum of one and three elements
	localparam int SUM_W   = ((FRAC_BITS > IN_W + 1) ? FRAC_BITS : IN_W + 1) + 2;
	localparam int SHIFT   = FRAC_BITS - 2;
	localparam int RAD_RAW = SUM_W - 1 + SHIFT;
	localparam int RAD_W   = RAD_RAW + (RAD_RAW % 2);
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int MAG_W   = FRAC_BITS + 1;
	localparam int CMP_W   = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;
	// accepting edge to result strobe
	localparam int LAT     = ROOT_W + 2;

	localparam int L_W = 0;
	localparam int L_X = 1;
	localparam int L_Y = 2;
	localparam int L_Z = 3;

	localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(1) << FRAC_BITS;
	localparam logic [MAG_W-1:0]        ONE_MAG = MAG_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_lane_t;

	typedef struct packed {
		logic pose;
		logic neg_x;
		logic neg_y;
		logic neg_z;
	} ctl_t;

	function automatic logic [MAG_W-1:0] sat_mag(input logic [ROOT_W-1:0] r);
		logic [CMP_W-1:0] rext;
		rext = CMP_W'(r);
		if (rext > CMP_W'(ONE_MAG)) begin
			return ONE_MAG;
		end
		return MAG_W'(rext);
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/rmq_front.sv
// Input stage: clamped diagonal sums, radicands and off-diagonal signs.
// Depends on rmq_pkg.
`default_nettype none
module rmq_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r00,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r01,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r02,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r10,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r11,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r12,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r20,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r21,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r22,
	input  wire logic                              pose_valid,
	output rmq_pkg::root_lane_t                    lanes [rmq_pkg::LANES],
	output rmq_pkg::ctl_t                          ctl,
	output logic                                   vld
);
	import rmq_pkg::*;

	logic signed [SUM_W-1:0] e00, e11, e22;
	logic signed [SUM_W-1:0] sum [LANES];
	logic [IN_W:0]           dx, dy, dz;
	root_lane_t              lane_s1 [LANES];
	ctl_t                    ctl_s1;
	logic                    vld_s1;

	assign e00 = SUM_W'(r00);
	assign e11 = SUM_W'(r11);
	assign e22 = SUM_W'(r22);

	assign sum[L_W] = ONE_SUM + e00 + e11 + e22;
	assign sum[L_X] = ONE_SUM + e00 - e11 - e22;
	assign sum[L_Y] = ONE_SUM - e00 + e11 - e22;
	assign sum[L_Z] = ONE_SUM - e00 - e11 + e22;

	assign dx = {r21[IN_W-1], r21} - {r12[IN_W-1], r12};
	assign dy = {r02[IN_W-1], r02} - {r20[IN_W-1], r20};
	assign dz = {r10[IN_W-1], r10} - {r01[IN_W-1], r01};

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			lane_s1[l].rem  <= '0;
			lane_s1[l].root <= '0;
			if (sum[l][SUM_W-1]) begin
				lane_s1[l].rad <= '0;
			end else begin
				lane_s1[l].rad <= RAD_W'(sum[l][SUM_W-2:0]) << SHIFT;
			end
		end
		ctl_s1.pose  <= pose_valid;
		ctl_s1.neg_x <= dx[IN_W];
		ctl_s1.neg_y <= dy[IN_W];
		ctl_s1.neg_z <= dz[IN_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	assign lanes = lane_s1;
	assign ctl   = ctl_s1;
	assign vld   = vld_s1;

endmodule
`default_nettype wire

>>> rtl/core/rmq_root_cell.sv
// One digit of a restoring square root: takes two radicand bits, makes one root bit.
// Depends on rmq_pkg.
`default_nettype none
module rmq_root_cell (
	input  wire logic          clk,
	input  wire rmq_pkg::root_lane_t din,
	output rmq_pkg::root_lane_t dout
);
	import rmq_pkg::*;

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             take;
	root_lane_t       lane_q;

	assign rem_sh = {din.rem, din.rad[RAD_W-1 -: 2]};
	assign trial  = (REM_W+2)'({din.root, 2'b01});
	assign diff   = rem_sh - trial;
	assign take   = rem_sh >= trial;

	always_ff @(posedge clk) begin
		lane_q.rad  <= din.rad << 2;
		lane_q.rem  <= take ? REM_W'(diff) : REM_W'(rem_sh);
		lane_q.root <= {din.root[ROOT_W-2:0], take};
	end

	assign dout = lane_q;

endmodule
`default_nettype wire

>>> rtl/core/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to unit quaternion, four square-root chains of digit cells.
// Pipeline: one input stage, one root cell per root bit (15), one output register; done is
// registered together with the result.
// Throughput: one beat per cycle; busy is never raised, results cannot be stalled.
// Reset: arst_n clears the beat-valid chain; no results are produced until new beats arrive.
// Depends on rmq_pkg, rmq_front, rmq_root_cell.
`default_nettype none
module rotation_matrix_to_quaternion_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r00,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r01,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r02,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r10,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r11,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r12,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r20,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r21,
	input  wire logic signed [rmq_pkg::IN_W-1:0]   r22,
	input  wire logic                              pose_valid,
	output logic                                   done,
	output logic [rmq_pkg::W_W-1:0]                quat_w,
	output logic signed [rmq_pkg::XYZ_W-1:0]       quat_x,
	output logic signed [rmq_pkg::XYZ_W-1:0]       quat_y,
	output logic signed [rmq_pkg::XYZ_W-1:0]       quat_z
);
	import rmq_pkg::*;

	localparam logic signed [XYZ_W-1:0] MAG_LIM = XYZ_W'(ONE_MAG);

	root_lane_t              lane [ROOT_W+1][LANES];
	ctl_t                    ctl_pipe_q [1:ROOT_W];
	logic [ROOT_W:1]         vld_pipe_q;
	ctl_t                    ctl_in;
	logic                    vld_in;
	logic [MAG_W-1:0]        mag [LANES];
	logic [XYZ_W-1:0]        mag_x, mag_y, mag_z;
	logic [W_W-1:0]          quat_w_q;
	logic [XYZ_W-1:0]        quat_x_q, quat_y_q, quat_z_q;
	logic                    done_q;
	ctl_t                    ctl_last;

	rmq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.r00        (r00),
		.r01        (r01),
		.r02        (r02),
		.r10        (r10),
		.r11        (r11),
		.r12        (r12),
		.r20        (r20),
		.r21        (r21),
		.r22        (r22),
		.pose_valid (pose_valid),
		.lanes      (lane[0]),
		.ctl        (ctl_in),
		.vld        (vld_in)
	);

	for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			rmq_root_cell u_cell (
				.clk  (clk),
				.din  (lane[s][l]),
				.dout (lane[s+1][l])
			);
		end
	end

	always_ff @(posedge clk) begin
		ctl_pipe_q[1] <= ctl_in;
		for (int s = 2; s <= ROOT_W; s++) begin
			ctl_pipe_q[s] <= ctl_pipe_q[s-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pipe_q <= '0;
		end else begin
			vld_pipe_q <= {vld_pipe_q[ROOT_W-1:1], vld_in};
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			mag[l] = sat_mag(lane[ROOT_W][l].root);
		end
	end

	assign ctl_last = ctl_pipe_q[ROOT_W];
	assign mag_x    = XYZ_W'(mag[L_X]);
	assign mag_y    = XYZ_W'(mag[L_Y]);
	assign mag_z    = XYZ_W'(mag[L_Z]);

	always_ff @(posedge clk) begin
		if (ctl_last.pose) begin
			quat_w_q <= W_W'(mag[L_W]);
			quat_x_q <= ctl_last.neg_x ? -mag_x : mag_x;
			quat_y_q <= ctl_last.neg_y ? -mag_y : mag_y;
			quat_z_q <= ctl_last.neg_z ? -mag_z : mag_z;
		end else begin
			quat_w_q <= W_W'(ONE_MAG);
			quat_x_q <= '0;
			quat_y_q <= '0;
			quat_z_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_pipe_q[ROOT_W];
		end
	end

	assign busy   = 1'b0;
	assign done   = done_q;
	assign quat_w = quat_w_q;
	assign quat_x = quat_x_q;
	assign quat_y = quat_y_q;
	assign quat_z = quat_z_q;

	a_beat_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(LAT) done)
		else $error("accepted beat produced no result");

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (W_W'(quat_w) <= W_W'(ONE_MAG)))
		else $error("quat_w above one");

	a_xyz_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((quat_x <= MAG_LIM) && (quat_x >= -MAG_LIM)
			&& (quat_y <= MAG_LIM) && (quat_y >= -MAG_LIM)
			&& (quat_z <= MAG_LIM) && (quat_z >= -MAG_LIM)))
		else $error("vector part magnitude above one");

endmodule
`default_nettype wire
